// ----- design/hdls_pkg.sv -----
// Package for the hysteresis dwell/lockout light switch.
// Shared types, register indexes and reset values; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hdls_pkg;

    // Field and register widths
    localparam int unsigned LUX_W      = 20;
    localparam int unsigned MS_W       = 16;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 20;

    // Default timer width
    localparam int unsigned TIMER_BITS_DEF = 16;

    // Register reset values
    localparam logic [LUX_W-1:0] DARK_THR_RST  = 20'd128;
    localparam logic [LUX_W-1:0] LIGHT_THR_RST = 20'd480;
    localparam logic [MS_W-1:0]  DWELL_RST     = 16'd2400;
    localparam logic [MS_W-1:0]  LOCKOUT_RST   = 16'd5000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DARK_THR  = 2'd0,
        CFG_LIGHT_THR = 2'd1,
        CFG_DWELL     = 2'd2,
        CFG_LOCKOUT   = 2'd3
    } t_cfg_idx;

    // Input word kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_ENABLE = 2'd2
    } t_kind;

    // Decision flags carried between the state registers and the step logic
    typedef struct packed {
        logic is_dark;
        logic enabled;
        logic resync;
        logic dwell_running;
    } t_flags;

    localparam t_flags FLAGS_RST = '{is_dark: 1'b0, enabled: 1'b0,
                                     resync: 1'b0, dwell_running: 1'b0};

endpackage

`default_nettype wire

// ----- design/hdls_step.sv -----
// Next-state logic for one input word of the light switch.
// Pure combinational; depends on hdls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hdls_step #(
    parameter int unsigned TIMER_BITS = hdls_pkg::TIMER_BITS_DEF
) (
    // current state
    input  wire hdls_pkg::t_flags                 i_flags,
    input  wire logic [TIMER_BITS-1:0]            i_dwell_elapsed,
    input  wire logic [TIMER_BITS-1:0]            i_lockout_left,
    // configuration
    input  wire logic [hdls_pkg::LUX_W-1:0]       i_dark_thr,
    input  wire logic [hdls_pkg::LUX_W-1:0]       i_light_thr,
    input  wire logic [hdls_pkg::MS_W-1:0]        i_dwell_ms,
    input  wire logic [hdls_pkg::MS_W-1:0]        i_lockout_ms,
    // input word
    input  wire logic [hdls_pkg::KIND_W-1:0]      i_kind,
    input  wire logic [hdls_pkg::LUX_W-1:0]       i_sample_value,
    input  wire logic                             i_enable_value,
    // next state and result
    output hdls_pkg::t_flags                      o_flags,
    output logic [TIMER_BITS-1:0]                 o_dwell_elapsed,
    output logic [TIMER_BITS-1:0]                 o_lockout_left,
    output logic                                  o_flipped
);

    // Common width for comparing timers against 16-bit settings
    localparam int unsigned CMP_W = (TIMER_BITS > hdls_pkg::MS_W) ? TIMER_BITS
                                                                  : hdls_pkg::MS_W;

    logic [CMP_W-1:0]      tmax_w;
    logic [CMP_W-1:0]      lock_w;
    logic [TIMER_BITS-1:0] lock_load;
    logic [TIMER_BITS-1:0] tmax;
    logic                  want_dark;
    logic                  dwell_done;

    // Saturated lockout load value and dwell compare
    always_comb begin
        tmax       = {TIMER_BITS{1'b1}};
        tmax_w     = CMP_W'(tmax);
        lock_w     = CMP_W'(i_lockout_ms);
        lock_load  = (lock_w > tmax_w) ? tmax : TIMER_BITS'(lock_w);
        dwell_done = !(CMP_W'(i_dwell_elapsed) < CMP_W'(i_dwell_ms));
    end

    // Hysteresis: only the threshold facing away from the current theme counts
    always_comb begin
        if (i_flags.is_dark) begin
            want_dark = !(i_sample_value > i_light_thr);
        end else begin
            want_dark = (i_sample_value < i_dark_thr);
        end
    end

    // Apply one word to the state
    always_comb begin
        o_flags         = i_flags;
        o_dwell_elapsed = i_dwell_elapsed;
        o_lockout_left  = i_lockout_left;
        o_flipped       = 1'b0;

        case (hdls_pkg::t_kind'(i_kind))
            hdls_pkg::KIND_SAMPLE: begin
                if (i_flags.enabled) begin
                    if (i_flags.resync || (want_dark != i_flags.is_dark &&
                            i_flags.dwell_running && dwell_done &&
                            i_lockout_left == '0)) begin
                        // commit the decision and start the lockout
                        o_flags.resync        = 1'b0;
                        o_flags.is_dark       = want_dark;
                        o_flags.dwell_running = 1'b0;
                        o_dwell_elapsed       = '0;
                        o_lockout_left        = lock_load;
                        o_flipped             = 1'b1;
                    end else if (want_dark == i_flags.is_dark) begin
                        // no change asked: drop the dwell
                        o_flags.dwell_running = 1'b0;
                        o_dwell_elapsed       = '0;
                    end else if (!i_flags.dwell_running) begin
                        // first contrary reading: start the dwell
                        o_flags.dwell_running = 1'b1;
                        o_dwell_elapsed       = '0;
                    end
                end
            end
            hdls_pkg::KIND_TICK: begin
                if (i_flags.dwell_running && i_dwell_elapsed != tmax) begin
                    o_dwell_elapsed = i_dwell_elapsed + 1'b1;
                end
                if (i_lockout_left != '0) begin
                    o_lockout_left = i_lockout_left - 1'b1;
                end
            end
            hdls_pkg::KIND_ENABLE: begin
                if (i_enable_value) begin
                    if (!i_flags.enabled) begin
                        o_flags.resync = 1'b1;
                    end
                    o_flags.enabled = 1'b1;
                end else begin
                    o_flags.enabled       = 1'b0;
                    o_flags.dwell_running = 1'b0;
                    o_dwell_elapsed       = '0;
                    o_lockout_left        = '0;
                end
            end
            default: begin
                // unused kind: state holds
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/hysteresis_dwell_lockout_switch_unit.sv -----
// Top level of the hysteresis dwell/lockout light switch.
// Depends on hdls_pkg and hdls_step.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one word: a light sample, a 1 ms
//   tick or an enable change, selected by i_kind. Output channel
//   (o_valid/i_ready) returns one word per input word: the theme after that
//   word, whether it flipped the theme, and whether a dwell is running.
//   A word is captured in the input register, then the step logic updates the
//   state and loads the result register. Throughput is one word per cycle
//   while the receiver does not stall; the state update is a single pass of
//   compares and a timer increment/decrement between the two registers.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more word; o_ready drops once both are full
//   and comes back the same cycle the receiver takes the result.
//   The configuration port writes one register per cycle with i_cfg_we;
//   write only while no word is in flight.
//   Reset (synchronous, i_rst_n low) restores the default thresholds and
//   timings, selects the light theme, disables the block, clears the dwell
//   and lockout timers and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module hysteresis_dwell_lockout_switch_unit #(
    parameter int unsigned TIMER_BITS = hdls_pkg::TIMER_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic [hdls_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [hdls_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input channel
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [hdls_pkg::KIND_W-1:0]         i_kind,
    input  wire logic [hdls_pkg::LUX_W-1:0]          i_sample_value,
    input  wire logic                                i_enable_value,
    // output channel
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic                                     o_theme_dark,
    output logic                                     o_flipped,
    output logic                                     o_pending
);

    // Configuration registers
    logic [hdls_pkg::LUX_W-1:0] r_dark_thr;
    logic [hdls_pkg::LUX_W-1:0] r_light_thr;
    logic [hdls_pkg::MS_W-1:0]  r_dwell_ms;
    logic [hdls_pkg::MS_W-1:0]  r_lockout_ms;

    // Input register
    logic                          r_in_valid;
    logic [hdls_pkg::KIND_W-1:0]   r_kind;
    logic [hdls_pkg::LUX_W-1:0]    r_sample;
    logic                          r_enable;

    // Decision state
    hdls_pkg::t_flags      r_flags;
    logic [TIMER_BITS-1:0] r_dwell;
    logic [TIMER_BITS-1:0] r_lockout;

    hdls_pkg::t_flags      n_flags;
    logic [TIMER_BITS-1:0] n_dwell;
    logic [TIMER_BITS-1:0] n_lockout;
    logic                  n_flipped;

    // Result register
    logic r_out_valid;
    logic r_theme;
    logic r_flip;
    logic r_pend;

    logic advance;
    logic in_take;

    // Move the held word into the result register when it is free
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign in_take = i_valid && o_ready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark_thr   <= hdls_pkg::DARK_THR_RST;
            r_light_thr  <= hdls_pkg::LIGHT_THR_RST;
            r_dwell_ms   <= hdls_pkg::DWELL_RST;
            r_lockout_ms <= hdls_pkg::LOCKOUT_RST;
        end else if (i_cfg_we) begin
            case (hdls_pkg::t_cfg_idx'(i_cfg_idx))
                hdls_pkg::CFG_DARK_THR:  r_dark_thr   <= i_cfg_data;
                hdls_pkg::CFG_LIGHT_THR: r_light_thr  <= i_cfg_data;
                hdls_pkg::CFG_DWELL:     r_dwell_ms   <= i_cfg_data[hdls_pkg::MS_W-1:0];
                hdls_pkg::CFG_LOCKOUT:   r_lockout_ms <= i_cfg_data[hdls_pkg::MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Capture the incoming word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind   <= i_kind;
            r_sample <= i_sample_value;
            r_enable <= i_enable_value;
        end
    end

    hdls_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .i_flags         (r_flags),
        .i_dwell_elapsed (r_dwell),
        .i_lockout_left  (r_lockout),
        .i_dark_thr      (r_dark_thr),
        .i_light_thr     (r_light_thr),
        .i_dwell_ms      (r_dwell_ms),
        .i_lockout_ms    (r_lockout_ms),
        .i_kind          (r_kind),
        .i_sample_value  (r_sample),
        .i_enable_value  (r_enable),
        .o_flags         (n_flags),
        .o_dwell_elapsed (n_dwell),
        .o_lockout_left  (n_lockout),
        .o_flipped       (n_flipped)
    );

    // Advance the decision state once per word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags   <= hdls_pkg::FLAGS_RST;
            r_dwell   <= '0;
            r_lockout <= '0;
        end else if (advance) begin
            r_flags   <= n_flags;
            r_dwell   <= n_dwell;
            r_lockout <= n_lockout;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_theme <= n_flags.is_dark;
            r_flip  <= n_flipped;
            r_pend  <= n_flags.dwell_running;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_theme_dark = r_theme;
    assign o_flipped    = r_flip;
    assign o_pending    = r_pend;

endmodule

`default_nettype wire
